[rtl/uem_pkg.sv]
// Shared types and constants of the UTF-8 error marker.
package uem_pkg;

    // UTF-8 encoding of U+2620, the marker put before a bad byte.
    localparam logic [7:0] MARK_B0 = 8'hE2;
    localparam logic [7:0] MARK_B1 = 8'h98;
    localparam logic [7:0] MARK_B2 = 8'hA0;

    // Byte classes.
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] LEAD2_LO   = 8'hC0;
    localparam logic [7:0] LEAD2_BAD  = 8'hC1;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_BAD  = 8'hF4;
    localparam logic [7:0] INVALID_LO = 8'hF8;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified byte, passed from the front to the back.
    typedef struct packed {
        logic [7:0] data;  // byte to pass on
        logic       flag;  // marker goes before the byte
        logic       tail;  // marker goes after the byte (stream ended mid-sequence)
    } t_desc;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Output sequencer states.
    typedef enum logic [2:0] {
        BK_START,
        BK_PRE1,
        BK_PRE2,
        BK_BYTE,
        BK_POST0,
        BK_POST1,
        BK_POST2
    } t_back_state;

endpackage

[rtl/uem_front.sv]
// Front end: accepts input bytes, tracks pending continuations, classifies each byte.
module uem_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_end_of_stream,
    input  uem_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output uem_pkg::t_desc         o_push_desc
);
    import uem_pkg::*;

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic [1:0] w_count;
    logic       w_flag;

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        w_flag  = 1'b0;
        w_count = r_pending;
        priority if (i_in_byte < CONT_LO) begin
            if (r_pending != 2'd0) begin
                w_flag  = 1'b1;
                w_count = 2'd0;
            end
        end else if (i_in_byte < LEAD2_LO) begin
            if (r_pending == 2'd0) begin
                w_flag = 1'b1;
            end else begin
                w_count = r_pending - 2'd1;
            end
        end else if (i_in_byte < LEAD3_LO) begin
            w_count = 2'd1;
            w_flag  = (i_in_byte <= LEAD2_BAD);
        end else if (i_in_byte < LEAD4_LO) begin
            w_count = 2'd2;
        end else if (i_in_byte < LEAD4_BAD) begin
            w_count = 2'd3;
        end else if (i_in_byte < INVALID_LO) begin
            w_flag  = 1'b1;
            w_count = 2'd3;
        end else begin
            w_flag  = 1'b1;
            w_count = 2'd0;
        end

        o_push_desc.data = i_in_byte;
        o_push_desc.flag = w_flag;
        o_push_desc.tail = i_end_of_stream && (w_count != 2'd0);

        n_pending = i_end_of_stream ? 2'd0 : w_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else if (o_push) begin
            r_pending <= n_pending;
        end
    end

endmodule

[rtl/uem_queue.sv]
// Two-entry queue of classified bytes between the front and the back.
module uem_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  uem_pkg::t_desc         i_push_desc,
    input  logic                   i_pop,
    output uem_pkg::t_desc         o_head,
    output uem_pkg::t_queue_status o_status
);
    import uem_pkg::*;

    t_desc                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/uem_back.sv]
// Back end: expands each classified byte into its output beats.
module uem_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  uem_pkg::t_desc         i_head,
    input  uem_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_of_run
);
    import uem_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    logic        w_done;
    logic        w_fire;

    assign o_out_valid = !i_q_status.empty;
    assign w_fire      = o_out_valid && i_out_ready;
    assign o_pop       = w_fire && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_START;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_out_byte    = i_head.data;
        o_last_of_run = 1'b0;
        w_done        = 1'b0;
        n_state       = r_state;
        unique case (r_state)
            BK_START: begin
                if (i_head.flag) begin
                    o_out_byte = MARK_B0;
                    n_state    = BK_PRE1;
                end else if (i_head.tail) begin
                    n_state = BK_POST0;
                end else begin
                    o_last_of_run = 1'b1;
                    w_done        = 1'b1;
                    n_state       = BK_START;
                end
            end
            BK_PRE1: begin
                o_out_byte = MARK_B1;
                n_state    = BK_PRE2;
            end
            BK_PRE2: begin
                o_out_byte = MARK_B2;
                n_state    = BK_BYTE;
            end
            BK_BYTE: begin
                if (i_head.tail) begin
                    n_state = BK_POST0;
                end else begin
                    o_last_of_run = 1'b1;
                    w_done        = 1'b1;
                    n_state       = BK_START;
                end
            end
            BK_POST0: begin
                o_out_byte = MARK_B0;
                n_state    = BK_POST1;
            end
            BK_POST1: begin
                o_out_byte = MARK_B1;
                n_state    = BK_POST2;
            end
            BK_POST2: begin
                o_out_byte    = MARK_B2;
                o_last_of_run = 1'b1;
                w_done        = 1'b1;
                n_state       = BK_START;
            end
            default: begin
                n_state = BK_START;
            end
        endcase
    end

endmodule

[rtl/utf8_error_marker_top.sv]
// Top level of the UTF-8 error marker: front end, queue and output sequencer.
//
// The block takes one byte per input beat and passes it on, putting the
// three-byte marker E2 98 A0 (U+2620) in front of every byte it finds in
// error: a stray continuation byte, an ASCII byte that cuts a pending
// sequence short (which also clears the count), the lead bytes C0 and C1,
// and every byte from F4 up. Lead bytes C0-DF, E0-EF and F0-F7 set the
// number of continuation bytes expected to 1, 2 and 3; F8-FF clear it.
// Overlong forms and surrogates are not checked. When the input beat that
// carries end_of_stream leaves continuations pending, one more marker
// follows that byte, and the count starts again from zero. Each input byte
// gives one to seven output beats, and last_of_run marks the final one.
// The output sequencer sends one beat per cycle while out_ready is high and
// an entry waits; a clean byte makes one beat and each marker adds three.
// A two-entry queue sits between the classifying front end and the output
// sequencer, so input beats keep being taken while output waits, until the
// queue is full.
module utf8_error_marker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import uem_pkg::*;

    // Classified bytes on their way from the front end to the sequencer.
    t_desc         w_push_desc;
    t_desc         w_head;
    t_queue_status w_q_status;
    logic          w_push;
    logic          w_pop;

    // The front end owns the continuation count and pushes one entry per
    // accepted input beat.
    uem_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_push_desc     (w_push_desc)
    );

    uem_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_desc (w_push_desc),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    // The sequencer walks through the beats of the head entry and pops it
    // when its last beat is taken.
    uem_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
